/* hdl/fapc_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and helpers for the feeder angle and phase controller
package fapc_pkg;

    // fixed geometry of the feeder drive
    localparam int STEP_COUNTS = 32768;
    localparam int STEP_LOG2   = $clog2(STEP_COUNTS);
    localparam int ENC_W       = 13;
    localparam int ENC_COUNTS  = 8192;
    localparam int ENC_HALF    = ENC_COUNTS / 2;
    localparam int MAX_DT_MS   = 200;
    localparam int DT_W        = $clog2(MAX_DT_MS + 1);
    localparam int NUM_W       = DT_W + STEP_LOG2;
    localparam int CNT_W       = $clog2(NUM_W + 1);
    localparam int GAIN_W      = 24;
    localparam int MAG_W       = 33;
    localparam int POS_W       = 40;
    localparam int CFG_W       = 24;

    // register map
    typedef enum logic [2:0] {
        REG_TIMEOUT    = 3'd0,
        REG_PERIOD     = 3'd1,
        REG_DEADBAND   = 3'd2,
        REG_HOLD_GAIN  = 3'd3,
        REG_HOLD_MAX   = 3'd4,
        REG_CONT_BASE  = 3'd5,
        REG_CONT_GAIN  = 3'd6,
        REG_CONT_MAX   = 3'd7
    } reg_idx_t;

    // switch codes
    localparam logic [1:0] SW_HOLD = 2'd1;
    localparam logic [1:0] SW_CONT = 2'd2;
    localparam logic [1:0] SW_STEP = 2'd3;

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_ERR  = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    // saturate a wide signed value to the 40-bit position range
    function automatic logic signed [POS_W-1:0] sat40(input logic signed [POS_W+1:0] v);
        logic signed [POS_W+1:0] hi;
        logic signed [POS_W+1:0] lo;
        hi = {3'b000, {(POS_W-1){1'b1}}};
        lo = {3'b111, {(POS_W-1){1'b0}}};
        if (v > hi) begin
            sat40 = hi[POS_W-1:0];
        end else if (v < lo) begin
            sat40 = lo[POS_W-1:0];
        end else begin
            sat40 = v[POS_W-1:0];
        end
    endfunction

endpackage

/* hdl/feeder_angle_phase_controller_top.sv */
`timescale 1ns / 1ps
// feeder angle and phase controller: sequencer, shared divider and multiplier
// One request at a time. A request passes the prepare, error, multiply and final states
// in hold and single-step modes, with bit-serial phase divide steps before the error
// state in continuous mode; a disabled request goes from prepare straight to final.
// The gain multiplier is a shift-add over the gain bits. The input is not ready until the
// result is loaded into the output register; a result may wait there for the
// sink while the next request is taken.
module feeder_angle_phase_controller_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [fapc_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_feeder_authorized,
    input  logic                            s_motor_online,
    input  logic [31:0]                     s_update_age_ms,
    input  logic [31:0]                     s_now_ms,
    input  logic [12:0]                     s_encoder_raw,
    input  logic [1:0]                      s_switch_pos,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [15:0]              m_speed_cmd_rpm,
    output logic                            m_pid_reset,
    output logic signed [39:0]              m_position_counts,
    output logic signed [39:0]              m_shown_target_counts,
    output logic signed [24:0]              m_target_rounds,
    output logic [23:0]                     m_actual_rounds
);
    import fapc_pkg::*;

    // configuration
    logic [15:0]        timeout_reg;
    logic [9:0]         period_reg;
    logic [15:0]        deadband_reg;
    logic [23:0]        hold_gain_reg;
    logic [14:0]        hold_max_reg;
    logic signed [15:0] cont_base_reg;
    logic [23:0]        cont_gain_reg;
    logic [14:0]        cont_max_reg;

    // request capture
    logic               auth_reg, online_reg;
    logic [31:0]        age_reg, now_reg;
    logic [ENC_W-1:0]   raw_reg;
    logic [1:0]         sw_reg;

    // controller state
    logic               init_reg;
    logic [ENC_W-1:0]   last_enc_reg;
    logic signed [POS_W-1:0] pos_reg, tgt_reg;
    logic [1:0]         prev_reg;
    logic [31:0]        tick_reg;
    logic [9:0]         rem_reg;
    logic signed [24:0] cmd_reg;
    logic [23:0]        done_reg;

    // working registers
    state_t             state_reg;
    logic               en_reg, rst_reg, dead_reg, neg_reg;
    logic [NUM_W-1:0]   div_reg;
    logic [9:0]         acc_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [MAG_W-1:0]   hi_reg;
    logic [GAIN_W-1:0]  lo_reg;

    logic               m_valid_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // prep stage: enable, unwrap, rounds, switch change, phase dividend
    logic               p_en, p_change, p_cont;
    logic [ENC_W-1:0]   p_last;
    logic signed [POS_W-1:0] p_pos0, p_pos, p_tgt;
    logic [1:0]         p_prev;
    logic [31:0]        p_tick, p_dt;
    logic [9:0]         p_rem;
    logic signed [14:0] p_d;
    logic [23:0]        p_comp, p_done;
    logic signed [24:0] p_cmd;
    logic [DT_W-1:0]    p_dtc;
    logic [NUM_W-1:0]   p_num;

    always_comb begin
        p_en   = auth_reg && online_reg && (age_reg <= {16'd0, timeout_reg});
        p_last = init_reg ? last_enc_reg : raw_reg;
        p_pos0 = init_reg ? pos_reg : '0;
        p_tgt  = init_reg ? tgt_reg : '0;
        p_prev = init_reg ? prev_reg : sw_reg;
        p_tick = init_reg ? tick_reg : now_reg;
        p_rem  = init_reg ? rem_reg : '0;
        p_d = 15'(signed'({2'b00, raw_reg})) - 15'(signed'({2'b00, p_last}));
        if (p_d > 15'(ENC_HALF)) begin
            p_d = p_d - 15'(ENC_COUNTS);
        end else if (p_d < -15'(ENC_HALF)) begin
            p_d = p_d + 15'(ENC_COUNTS);
        end
        p_pos  = sat40(42'(p_pos0) + 42'(p_d));
        p_comp = p_pos[POS_W-1] ? 24'd0 : 24'(p_pos >>> STEP_LOG2);
        p_done = (p_comp > done_reg) ? p_comp : done_reg;
        p_change = (sw_reg != p_prev);
        p_cmd  = cmd_reg;
        if (p_change) begin
            p_tgt  = p_pos;
            p_rem  = '0;
            p_tick = now_reg;
            if (sw_reg == SW_STEP && p_prev == SW_HOLD) begin
                p_tgt = sat40(42'(p_pos) + 42'(STEP_COUNTS));
                p_cmd = (cmd_reg == 25'sd16777215) ? cmd_reg : cmd_reg + 25'sd1;
            end
        end
        p_cont = (sw_reg == SW_CONT);
        p_dt   = now_reg - p_tick;
        p_dtc  = (p_dt > 32'(MAX_DT_MS)) ? DT_W'(MAX_DT_MS) : p_dt[DT_W-1:0];
        p_num  = {p_dtc, {STEP_LOG2{1'b0}}} + NUM_W'(p_rem);
    end

    // divide step: restoring, one quotient bit a cycle
    logic [9:0]  d_per;
    logic [10:0] d_trial;
    logic        d_bit;
    logic [10:0] d_diff;
    always_comb begin
        d_per   = (period_reg == '0) ? 10'd1 : period_reg;
        d_trial = {acc_reg, div_reg[NUM_W-1]};
        d_bit   = (d_trial >= {1'b0, d_per});
        d_diff  = d_trial - {1'b0, d_per};
    end

    // error stage: phase advance, relock, rounds, error magnitude
    logic signed [POS_W-1:0] e_tgt;
    logic signed [POS_W+1:0] e_err;
    logic [9:0]              e_rem;
    logic signed [24:0]      e_cmd;
    logic signed [POS_W+1:0] e_bias;
    logic [POS_W+1:0]        e_abs;
    logic                    e_dead;
    always_comb begin
        e_tgt = tgt_reg;
        e_rem = rem_reg;
        e_cmd = cmd_reg;
        if (sw_reg == SW_CONT) begin
            e_tgt = sat40(42'(tgt_reg) + 42'({1'b0, div_reg}));
            e_rem = acc_reg;
        end
        e_err = 42'(e_tgt) - 42'(pos_reg);
        if (sw_reg == SW_CONT &&
            (e_err > 42'sd65536 || e_err < -42'sd65536)) begin
            e_tgt = pos_reg;
            e_rem = '0;
            e_err = '0;
        end
        e_bias = e_tgt[POS_W-1] ? 42'(e_tgt) + 42'(STEP_COUNTS - 1) : 42'(e_tgt);
        if (sw_reg == SW_CONT) begin
            e_cmd = 25'(e_bias >>> STEP_LOG2);
        end
        e_abs  = e_err[POS_W+1] ? 42'(-e_err) : 42'(e_err);
        e_dead = (e_err < 42'($signed({1'b0, deadband_reg}))) &&
                 (e_err > -42'($signed({1'b0, deadband_reg})));
    end

    // multiply step: shift-add over the gain bits
    logic [MAG_W:0] m_sum;
    always_comb begin
        m_sum = lo_reg[0] ? {1'b0, hi_reg} + {1'b0, mag_reg} : {1'b0, hi_reg};
    end

    // final stage: scale, sign, base, clamp
    logic [POS_W:0]          f_p;
    logic [16:0]             f_ps;
    logic signed [18:0]      f_sp, f_v, f_max;
    logic signed [15:0]      f_speed;
    logic signed [POS_W+1:0] f_bias;
    logic signed [POS_W-1:0] f_shown;
    always_comb begin
        f_p  = {hi_reg, lo_reg[GAIN_W-1:16]};
        f_ps = (f_p > 41'd65535) ? 17'd65535 : f_p[16:0];
        f_sp = neg_reg ? -19'($signed({2'b00, f_ps})) : 19'($signed({2'b00, f_ps}));
        if (sw_reg == SW_CONT) begin
            f_v   = 19'(cont_base_reg) + f_sp;
            f_max = 19'($signed({1'b0, cont_max_reg}));
        end else begin
            f_v   = dead_reg ? 19'sd0 : f_sp;
            f_max = 19'($signed({1'b0, hold_max_reg}));
        end
        if (f_v > f_max) begin
            f_speed = f_max[15:0];
        end else if (f_v < -f_max) begin
            f_speed = 16'(-f_max);
        end else begin
            f_speed = f_v[15:0];
        end
        f_bias  = tgt_reg[POS_W-1] ? 42'(tgt_reg) + 42'(STEP_COUNTS - 1) : 42'(tgt_reg);
        f_shown = (sw_reg == SW_CONT) ?
                  40'((f_bias >>> STEP_LOG2) <<< STEP_LOG2) : tgt_reg;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= 16'd500;
            period_reg    <= 10'd50;
            deadband_reg  <= 16'd455;
            hold_gain_reg <= 24'd65536;
            hold_max_reg  <= 15'd3000;
            cont_base_reg <= 16'sd4800;
            cont_gain_reg <= 24'd65536;
            cont_max_reg  <= 15'd8000;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_TIMEOUT:   timeout_reg   <= cfg_wdata[15:0];
                REG_PERIOD:    period_reg    <= cfg_wdata[9:0];
                REG_DEADBAND:  deadband_reg  <= cfg_wdata[15:0];
                REG_HOLD_GAIN: hold_gain_reg <= cfg_wdata[23:0];
                REG_HOLD_MAX:  hold_max_reg  <= cfg_wdata[14:0];
                REG_CONT_BASE: cont_base_reg <= cfg_wdata[15:0];
                REG_CONT_GAIN: cont_gain_reg <= cfg_wdata[23:0];
                REG_CONT_MAX:  cont_max_reg  <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // request capture, unregistered-reset payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            auth_reg   <= s_feeder_authorized;
            online_reg <= s_motor_online;
            age_reg    <= s_update_age_ms;
            now_reg    <= s_now_ms;
            raw_reg    <= s_encoder_raw;
            sw_reg     <= s_switch_pos;
        end
    end

    // sequencer and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            init_reg     <= 1'b0;
            last_enc_reg <= '0;
            pos_reg      <= '0;
            tgt_reg      <= '0;
            prev_reg     <= '0;
            tick_reg     <= '0;
            rem_reg      <= '0;
            cmd_reg      <= '0;
            done_reg     <= '0;
            en_reg       <= 1'b0;
            rst_reg      <= 1'b0;
            dead_reg     <= 1'b0;
            neg_reg      <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    en_reg <= p_en;
                    if (!p_en) begin
                        init_reg  <= 1'b0;
                        cmd_reg   <= '0;
                        done_reg  <= '0;
                        state_reg <= ST_FIN;
                    end else begin
                        init_reg     <= 1'b1;
                        last_enc_reg <= raw_reg;
                        pos_reg      <= p_pos;
                        done_reg     <= p_done;
                        tgt_reg      <= p_tgt;
                        prev_reg     <= sw_reg;
                        tick_reg     <= p_cont ? now_reg : p_tick;
                        rem_reg      <= p_rem;
                        cmd_reg      <= p_cmd;
                        rst_reg      <= p_change;
                        div_reg      <= p_num;
                        acc_reg      <= '0;
                        cnt_reg      <= CNT_W'(NUM_W);
                        state_reg    <= p_cont ? ST_DIV : ST_ERR;
                    end
                end
                ST_DIV: begin
                    div_reg <= {div_reg[NUM_W-2:0], d_bit};
                    acc_reg <= d_bit ? d_diff[9:0] : d_trial[9:0];
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    tgt_reg   <= e_tgt;
                    rem_reg   <= e_rem;
                    cmd_reg   <= e_cmd;
                    dead_reg  <= e_dead;
                    neg_reg   <= e_err[POS_W+1];
                    mag_reg   <= (e_abs > 42'h1_0000_0000) ? 33'h1_0000_0000 : e_abs[MAG_W-1:0];
                    hi_reg    <= '0;
                    lo_reg    <= (sw_reg == SW_CONT) ? cont_gain_reg : hold_gain_reg;
                    cnt_reg   <= CNT_W'(GAIN_W);
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    hi_reg  <= m_sum[MAG_W:1];
                    lo_reg  <= {m_sum[0], lo_reg[GAIN_W-1:1]};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && (!m_valid_reg || m_ready)) begin
            if (en_reg) begin
                m_speed_cmd_rpm       <= f_speed;
                m_pid_reset           <= rst_reg;
                m_position_counts     <= pos_reg;
                m_shown_target_counts <= f_shown;
                m_target_rounds       <= cmd_reg;
                m_actual_rounds       <= done_reg;
            end else begin
                m_speed_cmd_rpm       <= '0;
                m_pid_reset           <= 1'b1;
                m_position_counts     <= '0;
                m_shown_target_counts <= '0;
                m_target_rounds       <= '0;
                m_actual_rounds       <= '0;
            end
        end
    end

endmodule
